### hdl/event_announcement_frame_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Event announcement frame sequencer: assertion macros
// Shared property forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EVENT_ANNOUNCEMENT_FRAME_SEQUENCER_DEFINES_SVH
`define EVENT_ANNOUNCEMENT_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define EAFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define EAFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/eafs_pkg.sv
// ----------------------------------------------------------------------------
// Event announcement frame sequencer package
// Opcodes, message codes, frame constants, text tables and shared types.
// ----------------------------------------------------------------------------
package eafs_pkg;

  // Request opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BOOT  = 2'd1;
  localparam logic [1:0] OP_SAVED = 2'd2;
  localparam logic [1:0] OP_INIT  = 2'd3;

  // Message codes
  localparam logic [3:0] MSG_BOOT      = 4'd0;
  localparam logic [3:0] MSG_ALARM_ON  = 4'd1;
  localparam logic [3:0] MSG_ALARM_OFF = 4'd2;
  localparam logic [3:0] MSG_MUTE_ON   = 4'd3;
  localparam logic [3:0] MSG_MUTE_OFF  = 4'd4;
  localparam logic [3:0] MSG_MODE_AUTO = 4'd5;
  localparam logic [3:0] MSG_MODE_MAN  = 4'd6;
  localparam logic [3:0] MSG_FAN_ON    = 4'd7;
  localparam logic [3:0] MSG_FAN_OFF   = 4'd8;
  localparam logic [3:0] MSG_SAVED     = 4'd9;

  // Message ring
  localparam int RING_DEPTH = 8;
  localparam int RING_IDX_W = $clog2(RING_DEPTH);

  // Command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Configuration
  localparam logic [15:0] COOLDOWN_RESET = 16'd200;

  // Frame layout
  localparam logic [7:0] FRAME_HEAD  = 8'hFD;
  localparam logic [7:0] SPEAK_CMD   = 8'h01;
  localparam logic [7:0] GBK_PARAM   = 8'h01;
  localparam logic [7:0] FRAME_EXTRA = 8'd3;
  localparam int         BIDX_W      = 5;
  localparam logic [BIDX_W-1:0] BIDX_HEAD   = 5'd0;
  localparam logic [BIDX_W-1:0] BIDX_LEN_HI = 5'd1;
  localparam logic [BIDX_W-1:0] BIDX_LEN_LO = 5'd2;
  localparam logic [BIDX_W-1:0] BIDX_CMD    = 5'd3;
  localparam logic [BIDX_W-1:0] BIDX_PARAM  = 5'd4;
  localparam logic [BIDX_W-1:0] BIDX_TEXT   = 5'd5;

  // Command handed from front to back
  typedef struct packed {
    logic       valid;
    logic [3:0] code;
  } cmd_t;

  // Text bytes of all messages, back to back
  localparam logic [7:0] TEXT_ROM [128] = '{
    8'hBF, 8'hD5, 8'hC6, 8'hF8, 8'hBC, 8'hE0, 8'hB2, 8'hE2, 8'hCF, 8'hB5,
    8'hCD, 8'hB3, 8'hD2, 8'hD1, 8'hC6, 8'hF4, 8'hB6, 8'hAF,
    8'hBF, 8'hD5, 8'hC6, 8'hF8, 8'hD6, 8'hCA, 8'hC1, 8'hBF, 8'hD2, 8'hEC,
    8'hB3, 8'hA3, 8'hA3, 8'hAC, 8'hC7, 8'hEB, 8'hD7, 8'hA2, 8'hD2, 8'hE2,
    8'hCD, 8'hA8, 8'hB7, 8'hE7,
    8'hBF, 8'hD5, 8'hC6, 8'hF8, 8'hD6, 8'hCA, 8'hC1, 8'hBF, 8'hBB, 8'hD6,
    8'hB8, 8'hB4, 8'hD5, 8'hFD, 8'hB3, 8'hA3,
    8'hB1, 8'hA8, 8'hBE, 8'hAF, 8'hD2, 8'hD1, 8'hBE, 8'hB2, 8'hD2, 8'hF4,
    8'hB1, 8'hA8, 8'hBE, 8'hAF, 8'hBE, 8'hB2, 8'hD2, 8'hF4, 8'hD2, 8'hD1,
    8'hC8, 8'hA1, 8'hCF, 8'hFB,
    8'hD7, 8'hD4, 8'hB6, 8'hAF, 8'hC4, 8'hA3, 8'hCA, 8'hBD,
    8'hCA, 8'hD6, 8'hB6, 8'hAF, 8'hC4, 8'hA3, 8'hCA, 8'hBD,
    8'hB7, 8'hE7, 8'hC9, 8'hC8, 8'hD2, 8'hD1, 8'hBF, 8'hAA, 8'hC6, 8'hF4,
    8'hB7, 8'hE7, 8'hC9, 8'hC8, 8'hD2, 8'hD1, 8'hB9, 8'hD8, 8'hB1, 8'hD5,
    8'hB2, 8'hCE, 8'hCA, 8'hFD, 8'hD2, 8'hD1, 8'hB1, 8'hA3, 8'hB4, 8'hE6
  };

  // First text byte of a message
  function automatic logic [6:0] text_start(input logic [3:0] code);
    logic [6:0] s;
    unique case (code)
      MSG_BOOT:      s = 7'd0;
      MSG_ALARM_ON:  s = 7'd18;
      MSG_ALARM_OFF: s = 7'd42;
      MSG_MUTE_ON:   s = 7'd58;
      MSG_MUTE_OFF:  s = 7'd68;
      MSG_MODE_AUTO: s = 7'd82;
      MSG_MODE_MAN:  s = 7'd90;
      MSG_FAN_ON:    s = 7'd98;
      MSG_FAN_OFF:   s = 7'd108;
      MSG_SAVED:     s = 7'd118;
      default:       s = 7'd0;
    endcase
    return s;
  endfunction

  // Text length of a message
  function automatic logic [BIDX_W-1:0] text_len(input logic [3:0] code);
    logic [BIDX_W-1:0] l;
    unique case (code)
      MSG_BOOT:      l = 5'd18;
      MSG_ALARM_ON:  l = 5'd24;
      MSG_ALARM_OFF: l = 5'd16;
      MSG_MUTE_ON:   l = 5'd10;
      MSG_MUTE_OFF:  l = 5'd14;
      MSG_MODE_AUTO: l = 5'd8;
      MSG_MODE_MAN:  l = 5'd8;
      MSG_FAN_ON:    l = 5'd10;
      MSG_FAN_OFF:   l = 5'd10;
      MSG_SAVED:     l = 5'd10;
      default:       l = 5'd10;
    endcase
    return l;
  endfunction

endpackage

### hdl/eafs_front.sv
// ----------------------------------------------------------------------------
// Event announcement frame sequencer: front end
// Accepts requests, detects flag changes, keeps the message ring and the
// cooldown, and hands one message code per spoken frame to the back end.
// ----------------------------------------------------------------------------
module eafs_front
  import eafs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic        alarm_active_i,
  input  logic        alarm_muted_i,
  input  logic        fan_on_i,
  input  logic        fan_manual_i,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output cmd_t        cmd_o,
  input  logic        cmd_full_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic                  state_q, state_d;
  logic                  prev_alarm_q, prev_alarm_d;
  logic                  prev_muted_q, prev_muted_d;
  logic                  prev_fan_q, prev_fan_d;
  logic                  prev_manual_q, prev_manual_d;
  logic [3:0]            ring_q [RING_DEPTH];
  logic [3:0]            ring_d [RING_DEPTH];
  logic [RING_IDX_W-1:0] wr_q, wr_d;
  logic [RING_IDX_W-1:0] rd_q, rd_d;
  logic [15:0]           cooldown_left_q, cooldown_left_d;
  logic [15:0]           cooldown_ticks_q;
  logic                  accept;
  logic                  push_vld [4];
  logic [3:0]            push_code [4];

  assign in_stall_o = (state_q == ST_POP);
  assign accept     = in_valid_i && !in_stall_o;

  // Hold the cooldown register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_ticks_q <= COOLDOWN_RESET;
    end else if (cfg_valid_i) begin
      cooldown_ticks_q <= cfg_data_i;
    end
  end

  // Collect the codes a request queues, in priority order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      push_vld[i]  = 1'b0;
      push_code[i] = MSG_BOOT;
    end
    unique case (opcode_i)
      OP_TICK: begin
        push_vld[0]  = alarm_active_i != prev_alarm_q;
        push_code[0] = alarm_active_i ? MSG_ALARM_ON : MSG_ALARM_OFF;
        push_vld[1]  = alarm_muted_i != prev_muted_q;
        push_code[1] = alarm_muted_i ? MSG_MUTE_ON : MSG_MUTE_OFF;
        push_vld[2]  = fan_manual_i != prev_manual_q;
        push_code[2] = fan_manual_i ? MSG_MODE_MAN : MSG_MODE_AUTO;
        push_vld[3]  = fan_manual_i && (fan_on_i != prev_fan_q);
        push_code[3] = fan_on_i ? MSG_FAN_ON : MSG_FAN_OFF;
      end
      OP_BOOT: begin
        push_vld[0]  = 1'b1;
        push_code[0] = MSG_BOOT;
      end
      OP_SAVED: begin
        push_vld[0]  = 1'b1;
        push_code[0] = MSG_SAVED;
      end
      OP_INIT: begin
      end
      default: begin
      end
    endcase
  end

  // Update ring, flags, cooldown and hand over frames
  always_comb begin
    logic [RING_IDX_W-1:0] wr_v;
    logic [RING_IDX_W-1:0] nxt_v;
    state_d         = state_q;
    prev_alarm_d    = prev_alarm_q;
    prev_muted_d    = prev_muted_q;
    prev_fan_d      = prev_fan_q;
    prev_manual_d   = prev_manual_q;
    ring_d          = ring_q;
    wr_d            = wr_q;
    rd_d            = rd_q;
    cooldown_left_d = cooldown_left_q;
    cmd_o.valid     = 1'b0;
    cmd_o.code      = ring_q[rd_q];
    wr_v            = wr_q;
    nxt_v           = wr_q;

    if (accept) begin
      if (opcode_i == OP_INIT) begin
        wr_d            = '0;
        rd_d            = '0;
        cooldown_left_d = '0;
        prev_alarm_d    = alarm_active_i;
        prev_muted_d    = alarm_muted_i;
        prev_fan_d      = fan_on_i;
        prev_manual_d   = fan_manual_i;
      end else begin
        // Queue codes, drop those that find the ring full
        for (int i = 0; i < 4; i++) begin
          nxt_v = (wr_v == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : wr_v + 1'b1;
          if (push_vld[i] && (nxt_v != rd_q)) begin
            ring_d[wr_v] = push_code[i];
            wr_v         = nxt_v;
          end
        end
        wr_d = wr_v;
        if (opcode_i == OP_TICK) begin
          prev_alarm_d  = alarm_active_i;
          prev_muted_d  = alarm_muted_i;
          prev_manual_d = fan_manual_i;
          prev_fan_d    = fan_on_i;
          state_d       = ST_POP;
        end
      end
    end else if (state_q == ST_POP) begin
      // Count down, or pop one code for the back end
      if (cooldown_left_q != '0) begin
        cooldown_left_d = cooldown_left_q - 16'd1;
        state_d         = ST_IDLE;
      end else if (rd_q == wr_q) begin
        state_d = ST_IDLE;
      end else if (!cmd_full_i) begin
        cmd_o.valid     = 1'b1;
        rd_d            = (rd_q == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : rd_q + 1'b1;
        cooldown_left_d = cooldown_ticks_q;
        state_d         = ST_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      prev_alarm_q    <= 1'b0;
      prev_muted_q    <= 1'b0;
      prev_fan_q      <= 1'b0;
      prev_manual_q   <= 1'b0;
      wr_q            <= '0;
      rd_q            <= '0;
      cooldown_left_q <= '0;
    end else begin
      state_q         <= state_d;
      prev_alarm_q    <= prev_alarm_d;
      prev_muted_q    <= prev_muted_d;
      prev_fan_q      <= prev_fan_d;
      prev_manual_q   <= prev_manual_d;
      wr_q            <= wr_d;
      rd_q            <= rd_d;
      cooldown_left_q <= cooldown_left_d;
    end
  end

  // Ring contents carry no reset
  always_ff @(posedge clk_i) begin
    ring_q <= ring_d;
  end

endmodule

### hdl/eafs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Event announcement frame sequencer: command queue
// Short queue of message codes between the front and back ends.
// ----------------------------------------------------------------------------
module eafs_cmd_fifo
  import eafs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t push_i,
  output logic full_o,
  output cmd_t head_o,
  input  logic pop_i
);

  logic [3:0]           mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wptr_q, rptr_q;
  logic [CMD_CNT_W-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o      = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.code  = mem_q[rptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  // Store pushed codes
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.code;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hdl/eafs_back.sv
// ----------------------------------------------------------------------------
// Event announcement frame sequencer: back end
// Walks one speak frame per queued code, one byte a cycle while the output is not stalled, into a
// registered output stage, folding the checksum as it goes.
// ----------------------------------------------------------------------------
module eafs_back
  import eafs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic [3:0] message_code_o,
  output logic       last_byte_o
);

  logic [BIDX_W-1:0] idx_q, idx_d;
  logic [7:0]        ecc_q, ecc_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        byte_q;
  logic [3:0]        code_q;
  logic              last_q;
  logic              load;
  logic [BIDX_W-1:0] len;
  logic [BIDX_W-1:0] last_idx;
  logic [15:0]       flen;
  logic [6:0]        rom_addr;
  logic [7:0]        byte_v;
  logic              is_last;

  assign len      = text_len(head_i.code);
  assign last_idx = len + BIDX_TEXT;
  assign flen     = {11'd0, len} + {8'd0, FRAME_EXTRA};
  assign rom_addr = text_start(head_i.code) + {2'd0, idx_q} - {2'd0, BIDX_TEXT};
  assign is_last  = (idx_q == last_idx);
  assign load     = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o    = load && is_last;

  // Select the byte at the current position
  always_comb begin
    if (is_last) begin
      byte_v = ecc_q;
    end else begin
      case (idx_q)
        BIDX_HEAD:   byte_v = FRAME_HEAD;
        BIDX_LEN_HI: byte_v = flen[15:8];
        BIDX_LEN_LO: byte_v = flen[7:0];
        BIDX_CMD:    byte_v = SPEAK_CMD;
        BIDX_PARAM:  byte_v = GBK_PARAM;
        default:     byte_v = TEXT_ROM[rom_addr];
      endcase
    end
  end

  // Advance position and checksum
  always_comb begin
    idx_d       = idx_q;
    ecc_d       = ecc_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (is_last) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
        ecc_d = (idx_q == BIDX_HEAD) ? byte_v : (ecc_q ^ byte_v);
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload and checksum carry no reset
  always_ff @(posedge clk_i) begin
    ecc_q <= ecc_d;
    if (load) begin
      byte_q <= byte_v;
      code_q <= head_i.code;
      last_q <= is_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_byte_o   = byte_q;
  assign message_code_o = code_q;
  assign last_byte_o    = last_q;

endmodule

### hdl/event_announcement_frame_sequencer.sv
// A tick's code passes the front-end pop state, the command queue and the back-end output register.
// A tick holds the front end in its pop state, longer while the command queue is full;
// queue and init requests do not hold it. A frame is text length + 6 bytes (14 to 30),
// one per cycle while the output is not stalled, from the back-end output register.
// Reset (asynchronous, active low): flags clear, ring and command queue empty, cooldown 0,
// cooldown register 200. Ring contents are not cleared.
// ----------------------------------------------------------------------------
// Event announcement frame sequencer
// Turns status flag changes and explicit requests into queued messages and
// emits at most one speak command frame per tick after the cooldown runs out.
// ----------------------------------------------------------------------------
`include "event_announcement_frame_sequencer_defines.svh"

module event_announcement_frame_sequencer
  import eafs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic        alarm_active_i,
  input  logic        alarm_muted_i,
  input  logic        fan_on_i,
  input  logic        fan_manual_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic [3:0]  message_code_o,
  output logic        last_byte_o
);

  cmd_t cmd_push;
  cmd_t cmd_head;
  logic cmd_full;
  logic cmd_pop;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  eafs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .alarm_active_i (alarm_active_i),
    .alarm_muted_i  (alarm_muted_i),
    .fan_on_i       (fan_on_i),
    .fan_manual_i   (fan_manual_i),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cmd_o          (cmd_push),
    .cmd_full_i     (cmd_full)
  );

  eafs_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .full_o (cmd_full),
    .head_o (cmd_head),
    .pop_i  (cmd_pop)
  );

  eafs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (cmd_head),
    .pop_o          (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .message_code_o (message_code_o),
    .last_byte_o    (last_byte_o)
  );

  // Front never hands a code to a full queue
  `EAFS_ASSERT_NOW(a_no_push_when_full, cmd_full, !cmd_push.valid, "push into full queue")

  // Back only retires a frame that is queued
  `EAFS_ASSERT_NOW(a_pop_needs_head, cmd_pop, cmd_head.valid, "pop from empty queue")

  // An accepted tick keeps the front busy for its pop decision
  `EAFS_ASSERT_NEXT(a_tick_busy, in_valid_i && !in_stall_o && (opcode_i == OP_TICK), in_stall_o, "tick did not hold front")

  // The closing byte is shown only after its frame left the queue
  `EAFS_ASSERT_NEXT(a_last_after_pop, cmd_pop, out_valid_o && last_byte_o, "checksum byte missing after pop")

endmodule
